// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, sampled on the rising clock, off during reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/tpt_pkg.sv =====
`default_nettype none

package tpt_pkg;

  localparam int unsigned VA_W  = 20;
  localparam int unsigned CNT_W = 32;

  localparam int unsigned TLB_ENTRIES_DEF  = 16;
  localparam int unsigned PAGE_COUNT_DEF   = 1024;
  localparam int unsigned OFFSET_WIDTH_DEF = 10;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_READ,
    ST_RESOLVE
  } tpt_state_e;

  typedef struct packed {
    logic clear_en;
    logic load_va;
    logic div_en;
    logic mul_en;
    logic read_en;
    logic commit;
  } tpt_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic out_busy;
  } tpt_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/tpt_if.sv =====
`default_nettype none

interface tpt_va_if import tpt_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [VA_W-1:0] virtual_address;

  modport source (output valid, output virtual_address, input ready);
  modport sink (input valid, input virtual_address, output ready);
endinterface

interface tpt_pa_if import tpt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VA_W-1:0]  phys_addr;
  logic             tlb_hit;
  logic             page_fault;
  logic [CNT_W-1:0] hit_total;
  logic [CNT_W-1:0] fault_total;

  modport source (output valid, output phys_addr, output tlb_hit, output page_fault,
                  output hit_total, output fault_total, input ready);
  modport sink (input valid, input phys_addr, input tlb_hit, input page_fault,
                input hit_total, input fault_total, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tpt_ctrl.sv =====
`default_nettype none

module tpt_ctrl import tpt_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire tpt_status_t status_i,
  output tpt_cmd_t         cmd_o
);

  tpt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (status_i.clear_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DIV;
      end
      ST_DIV:  state_d = ST_MUL;
      ST_MUL:  state_d = ST_READ;
      ST_READ: state_d = ST_RESOLVE;
      ST_RESOLVE: begin
        // hold until the previous word has left the output register
        if (!status_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clear_en = 1'b1;
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_va = in_valid_i;
      end
      ST_DIV:     cmd_o.div_en  = 1'b1;
      ST_MUL:     cmd_o.mul_en  = 1'b1;
      ST_READ:    cmd_o.read_en = 1'b1;
      ST_RESOLVE: cmd_o.commit  = !status_i.out_busy;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/tpt_datapath.sv =====
`default_nettype none

module tpt_datapath import tpt_pkg::*; #(
  parameter int unsigned TLB_ENTRIES  = TLB_ENTRIES_DEF,
  parameter int unsigned PAGE_COUNT   = PAGE_COUNT_DEF,
  parameter int unsigned OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire tpt_cmd_t         cmd_i,
  output tpt_status_t           status_o,
  input  wire logic [VA_W-1:0]  virtual_address_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [VA_W-1:0]       phys_addr_o,
  output logic                  tlb_hit_o,
  output logic                  page_fault_o,
  output logic [CNT_W-1:0]      hit_total_o,
  output logic [CNT_W-1:0]      fault_total_o
);

  localparam int unsigned PW     = VA_W - OFFSET_WIDTH;
  localparam int unsigned AW     = $clog2(PAGE_COUNT);
  localparam int unsigned TW     = $clog2(TLB_ENTRIES);
  localparam int unsigned SH     = PW + AW;
  localparam int unsigned PROD_W = 2 * PW + 1;
  // round-up reciprocal, exact quotient for every PW-bit page number
  localparam longint unsigned RECIP_L =
    ((64'd1 << SH) + 64'(PAGE_COUNT) - 64'd1) / 64'(PAGE_COUNT);
  localparam logic [PW:0]   RECIP    = (PW + 1)'(RECIP_L);
  localparam logic [PW-1:0] PAGE_LOW = PW'(PAGE_COUNT);
  localparam logic [AW-1:0] LAST_ROW = AW'(PAGE_COUNT - 1);
  localparam logic [TW-1:0] LAST_SLOT = TW'(TLB_ENTRIES - 1);

  logic [VA_W-1:0]   va_q;
  logic [PROD_W-1:0] prod_q;
  logic [AW-1:0]     page_q;
  logic [AW:0]       rd_q;
  logic [AW-1:0]     clr_q;
  logic [AW-1:0]     free_q;
  logic [TW-1:0]     victim_q;
  logic [CNT_W-1:0]  hit_cnt_q, fault_cnt_q;
  logic              out_valid_q;
  logic [VA_W-1:0]   pa_q;
  logic              hit_flag_q, fault_flag_q;

  logic [AW-1:0]     tag_q   [TLB_ENTRIES];
  logic [AW-1:0]     frame_q [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] tvalid_q;

  logic [AW:0]       map_mem [PAGE_COUNT];

  logic [PW-1:0]         page_raw;
  logic [OFFSET_WIDTH-1:0] offset;
  logic [PW-1:0]         quot;
  logic [PW-1:0]         rem;
  logic                  hit;
  logic [AW-1:0]         hit_frame;
  logic                  map_valid;
  logic                  fault;
  logic [AW-1:0]         frame;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [AW:0]           mem_wdata;

  assign page_raw = va_q[VA_W-1:OFFSET_WIDTH];
  assign offset   = va_q[OFFSET_WIDTH-1:0];
  assign quot     = PW'(prod_q >> SH);
  // modulo 2**PW keeps the product exact since quot * PAGE_COUNT fits PW bits
  assign rem      = page_raw - PW'(quot * PAGE_LOW);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_va) va_q <= virtual_address_i;
    if (cmd_i.div_en) prod_q <= PROD_W'(page_raw) * PROD_W'(RECIP);
    if (cmd_i.mul_en) page_q <= AW'(rem);
  end

  // lowest valid matching slot wins
  always_comb begin
    hit       = 1'b0;
    hit_frame = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tvalid_q[i] && tag_q[i] == page_q) begin
        hit       = 1'b1;
        hit_frame = frame_q[i];
      end
    end
  end

  assign map_valid = rd_q[AW];
  assign fault     = !hit && !map_valid;

  always_comb begin
    priority if (hit) begin
      frame = hit_frame;
    end else if (map_valid) begin
      frame = rd_q[AW-1:0];
    end else begin
      frame = free_q;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = page_q;
    mem_wdata = {1'b1, free_q};
    if (cmd_i.clear_en) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (cmd_i.commit && fault) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) map_mem[mem_waddr] <= mem_wdata;
    if (cmd_i.read_en) rd_q <= map_mem[page_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && !hit) begin
      tag_q[victim_q]   <= page_q;
      frame_q[victim_q] <= frame;
    end
    if (cmd_i.commit) begin
      pa_q         <= VA_W'({frame, offset});
      hit_flag_q   <= hit;
      fault_flag_q <= fault;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      free_q      <= '0;
      victim_q    <= '0;
      tvalid_q    <= '0;
      hit_cnt_q   <= '0;
      fault_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear_en) clr_q <= clr_q + 1'b1;
      if (cmd_i.commit) begin
        if (hit) begin
          if (hit_cnt_q != '1) hit_cnt_q <= hit_cnt_q + 1'b1;
        end else begin
          tvalid_q[victim_q] <= 1'b1;
          victim_q <= (victim_q == LAST_SLOT) ? '0 : victim_q + 1'b1;
          if (fault) begin
            free_q <= free_q + 1'b1;
            if (fault_cnt_q != '1) fault_cnt_q <= fault_cnt_q + 1'b1;
          end
        end
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.clear_done = cmd_i.clear_en && (clr_q == LAST_ROW);
  assign status_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o        = out_valid_q;
  assign phys_addr_o        = pa_q;
  assign tlb_hit_o          = hit_flag_q;
  assign page_fault_o       = fault_flag_q;
  assign hit_total_o        = hit_cnt_q;
  assign fault_total_o      = fault_cnt_q;

endmodule

`default_nettype wire

// ===== rtl/core/tlb_page_table_translator_top.sv =====
// channel  dir  payload                                              handshake
// va_i     in   virtual_address[19:0]                                valid/ready
// pa_o     out  phys_addr, tlb_hit, page_fault, hit_total,           valid/ready
//               fault_total
//
// one address at a time: accept, reciprocal multiply, remainder,
// page table read, then resolve and tlb fill in one step
// after reset the page table is swept clear row by row, va_i.ready low
// the result sits in an output register; resolve waits while that word is unread
// an accepted address passes DIV, MUL, READ and RESOLVE; pa_o.valid is registered from the commit

`default_nettype none

`include "assert_macros.svh"

module tlb_page_table_translator_top import tpt_pkg::*; #(
  parameter int unsigned TLB_ENTRIES  = TLB_ENTRIES_DEF,
  parameter int unsigned PAGE_COUNT   = PAGE_COUNT_DEF,
  parameter int unsigned OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tpt_va_if.sink    va_i,
  tpt_pa_if.source  pa_o
);

  tpt_cmd_t    cmd;
  tpt_status_t status;
  logic        in_ready;

  tpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (va_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  assign va_i.ready = in_ready;

  tpt_datapath #(
    .TLB_ENTRIES  (TLB_ENTRIES),
    .PAGE_COUNT   (PAGE_COUNT),
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .virtual_address_i  (va_i.virtual_address),
    .out_valid_o        (pa_o.valid),
    .out_ready_i        (pa_o.ready),
    .phys_addr_o        (pa_o.phys_addr),
    .tlb_hit_o          (pa_o.tlb_hit),
    .page_fault_o       (pa_o.page_fault),
    .hit_total_o        (pa_o.hit_total),
    .fault_total_o      (pa_o.fault_total)
  );

  `ASSERT_NEXT(a_one_in_flight, va_i.valid && va_i.ready, !va_i.ready)
  `ASSERT_IMPL(a_hit_no_fault, pa_o.valid && pa_o.tlb_hit, !pa_o.page_fault)
  `ASSERT_NEXT(a_commit_shows, cmd.commit, pa_o.valid)

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tpt_pkg::*;

  localparam int unsigned N_RANDOM   = 500;
  localparam int unsigned WSET_SIZE  = 24;
  localparam int unsigned IDLE_LIMIT = 8000;
  localparam int unsigned HOLD_LEN   = 300;
  localparam int unsigned DRAIN_LEN  = 30;

  typedef struct packed {
    logic [VA_W-1:0]  phys_addr;
    logic             tlb_hit;
    logic             page_fault;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] fault_total;
  } pa_word_t;

  logic clk_i;
  logic rst_ni;

  tpt_va_if va_if ();
  tpt_pa_if pa_if ();

  tlb_page_table_translator_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .va_i  (va_if),
    .pa_o  (pa_if)
  );

  always #2 clk_i = ~clk_i;

  // translation state mirrored from the block
  logic [9:0]       tlb_page_q  [TLB_ENTRIES_DEF];
  logic [9:0]       tlb_frame_q [TLB_ENTRIES_DEF];
  logic             tlb_vld_q   [TLB_ENTRIES_DEF];
  int unsigned      fill_ptr;
  logic             map_vld     [PAGE_COUNT_DEF];
  logic [10:0]      map_frame   [PAGE_COUNT_DEF];
  int unsigned      free_frame;
  logic [CNT_W-1:0] hit_cnt;
  logic [CNT_W-1:0] fault_cnt;

  logic [VA_W-1:0] pending_va [$];
  pa_word_t        expected_pa [$];

  int unsigned n_items;
  int unsigned n_accepted;
  int unsigned n_seen;
  int unsigned n_err;
  int unsigned idle_cycles;
  bit          va_taken;
  bit          hold;

  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned rx_mode;
  int unsigned rx_mode_left;

  function automatic void translate_va(logic [VA_W-1:0] va);
    int unsigned page;
    int unsigned offset;
    int unsigned frame;
    int unsigned slot;
    bit          hit;
    bit          fault;
    pa_word_t    w;
    page   = (int'(va) >> OFFSET_WIDTH_DEF) % PAGE_COUNT_DEF;
    offset = int'(va) & ((1 << OFFSET_WIDTH_DEF) - 1);
    frame  = 0;
    hit    = 0;
    fault  = 0;
    // lowest matching slot wins
    for (int i = 0; i < TLB_ENTRIES_DEF; i++) begin
      if (!hit && tlb_vld_q[i] && tlb_page_q[i] == page[9:0]) begin
        hit   = 1;
        frame = 32'(tlb_frame_q[i]);
      end
    end
    if (hit) begin
      if (hit_cnt != '1) hit_cnt = hit_cnt + 1;
    end else begin
      if (map_vld[page]) begin
        frame = 32'(map_frame[page]);
      end else begin
        frame           = free_frame % PAGE_COUNT_DEF;
        map_vld[page]   = 1'b1;
        map_frame[page] = frame[10:0];
        free_frame      = (free_frame + 1) & 16'hFFFF;
        if (fault_cnt != '1) fault_cnt = fault_cnt + 1;
        fault = 1;
      end
      slot              = fill_ptr % TLB_ENTRIES_DEF;
      tlb_page_q[slot]  = page[9:0];
      tlb_frame_q[slot] = frame[9:0];
      tlb_vld_q[slot]   = 1'b1;
      fill_ptr          = (slot + 1) % TLB_ENTRIES_DEF;
    end
    w.phys_addr   = VA_W'(((frame << OFFSET_WIDTH_DEF) | offset) & 32'hFFFFF);
    w.tlb_hit     = hit;
    w.page_fault  = fault;
    w.hit_total   = hit_cnt;
    w.fault_total = fault_cnt;
    expected_pa.push_back(w);
  endfunction

  function automatic void check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
    if (want !== got) begin
      $display("%t mismatch %s: expected %h actual %h", $realtime, name, want, got);
      n_err++;
    end
  endfunction

  // sampling side: accepted words, result check, watchdog
  always @(posedge clk_i) begin : mon
    pa_word_t want;
    va_taken = rst_ni && va_if.valid && va_if.ready;
    if (va_taken) begin
      translate_va(va_if.virtual_address);
      n_accepted++;
    end
    if (rst_ni && pa_if.valid && pa_if.ready) begin
      n_seen++;
      if (expected_pa.size() == 0) begin
        $display("%t unexpected word: expected none actual pa %h hit %b fault %b",
                 $realtime, pa_if.phys_addr, pa_if.tlb_hit, pa_if.page_fault);
        n_err++;
      end else begin
        want = expected_pa.pop_front();
        check_field("phys_addr", CNT_W'(want.phys_addr), CNT_W'(pa_if.phys_addr));
        check_field("tlb_hit", CNT_W'(want.tlb_hit), CNT_W'(pa_if.tlb_hit));
        check_field("page_fault", CNT_W'(want.page_fault), CNT_W'(pa_if.page_fault));
        check_field("hit_total", want.hit_total, pa_if.hit_total);
        check_field("fault_total", want.fault_total, pa_if.fault_total);
      end
    end
    if (va_taken || (pa_if.valid && pa_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%t watchdog: no word moved for %0d cycles", $realtime, idle_cycles);
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // address driver: bursts with random gaps
  always @(negedge clk_i) begin
    if (rst_ni && (!va_if.valid || va_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        va_if.valid <= 1'b0;
      end else if (pending_va.size() > 0) begin
        va_if.valid           <= 1'b1;
        va_if.virtual_address <= pending_va.pop_front();
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(30, 1);
          gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
        end
      end else begin
        va_if.valid <= 1'b0;
      end
    end
  end

  // result receiver: stall pattern changes mode every so often
  always @(negedge clk_i) begin : rx
    logic rdy;
    if (!rst_ni) begin
      rdy = 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(2, 0);
        rx_mode_left = $urandom_range(200, 20);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        0: rdy = 1'b1;
        1: rdy = 1'($urandom_range(1, 0));
        default: rdy = ($urandom_range(3, 0) == 0);
      endcase
      if (hold) rdy = 1'b0;
    end
    pa_if.ready <= rdy;
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    hold = 0;
    wait (n_accepted >= 150);
    @(posedge clk_i);
    hold = 1;
    repeat (HOLD_LEN) @(posedge clk_i);
    hold = 0;
  end

  initial begin : stim
    logic [9:0] wset [WSET_SIZE];
    logic [9:0] last_page;
    logic [9:0] pg;
    int unsigned pick;

    clk_i                 = 1'b0;
    rst_ni                = 1'b0;
    va_if.valid           = 1'b0;
    va_if.virtual_address = '0;
    pa_if.ready           = 1'b0;
    va_taken              = 0;
    n_accepted            = 0;
    n_seen                = 0;
    n_err                 = 0;
    idle_cycles           = 0;
    burst_left            = $urandom_range(30, 1);
    gap_left              = 0;
    rx_mode               = 0;
    rx_mode_left          = 0;
    fill_ptr              = 0;
    free_frame            = 0;
    hit_cnt               = '0;
    fault_cnt             = '0;
    for (int i = 0; i < TLB_ENTRIES_DEF; i++) begin
      tlb_vld_q[i]   = 1'b0;
      tlb_page_q[i]  = '0;
      tlb_frame_q[i] = '0;
    end
    for (int i = 0; i < PAGE_COUNT_DEF; i++) begin
      map_vld[i]   = 1'b0;
      map_frame[i] = '0;
    end

    // directed: first fault, hit on same page, top page, then wrap the fifo
    pending_va.push_back(20'h00000);
    pending_va.push_back(20'h003FF);
    pending_va.push_back(20'hFFFFF);
    pending_va.push_back(20'hFFC00);
    for (int p = 1; p <= 16; p++) begin
      pending_va.push_back({p[9:0], (p[0] ? 10'h3FF : 10'h000) ^ 10'(p * 37)});
    end
    // both early pages are evicted now: tlb miss but page table hit
    pending_va.push_back(20'h00155);
    pending_va.push_back(20'hFFEAA);

    for (int i = 0; i < WSET_SIZE; i++) wset[i] = 10'($urandom_range(1023, 0));
    last_page = '0;
    for (int i = 0; i < N_RANDOM; i++) begin
      pick = $urandom_range(99, 0);
      if (pick < 65) begin
        pg = wset[$urandom_range(WSET_SIZE - 1, 0)];
      end else if (pick < 80) begin
        pg = last_page;
      end else begin
        pg = 10'($urandom_range(1023, 0));
      end
      last_page = pg;
      pending_va.push_back({pg, 10'($urandom_range(1023, 0))});
    end
    n_items = pending_va.size();

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (n_accepted == n_items && n_seen >= n_accepted);
    repeat (DRAIN_LEN) @(posedge clk_i);
    if (expected_pa.size() != 0) begin
      $display("%t %0d expected words never arrived", $realtime, expected_pa.size());
      n_err++;
    end
    if (n_err == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
